// ----- sv/slpg_pkg.sv -----
// slpg_pkg: shared types, mode and request codes and colour constants
// for the status pixel pattern generator; no dependencies
`timescale 1ns / 1ps

package slpg_pkg;

    typedef logic [3:0] t_mode;
    typedef logic [7:0] t_chan;
    typedef logic [7:0] t_phase;
    typedef logic [3:0] t_ph10;
    typedef logic [6:0] t_ph100;

    // request codes
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SET  = 1'b1;

    // display modes
    localparam t_mode MODE_BOOT      = 4'd0;
    localparam t_mode MODE_IDLE      = 4'd1;
    localparam t_mode MODE_NO_SERVER = 4'd2;
    localparam t_mode MODE_CALLING   = 4'd3;
    localparam t_mode MODE_RINGING   = 4'd4;
    localparam t_mode MODE_IN_CALL   = 4'd5;
    localparam t_mode MODE_FAILED    = 4'd6;
    localparam t_mode MODE_ERROR     = 4'd7;
    localparam t_mode MODE_LOOPBACK  = 4'd8;

    // phase counter wrap points and the failed-mode display limit
    localparam t_phase PHASE_LAST = 8'd199;
    localparam t_ph10  PH10_LAST  = 4'd9;
    localparam t_ph100 PH100_LAST = 7'd99;
    localparam t_phase FAIL_LAST  = 8'd30;

    // brightness levels
    localparam t_chan BRI_IDLE   = 8'd30;
    localparam t_chan BRI_NOSRV  = 8'd25;
    localparam t_chan BRI_HIGH   = 8'd200;
    localparam t_chan BRI_RING   = 8'd220;
    localparam t_chan BRI_ERROR  = 8'd180;

    // full channels scale to the brightness itself; the yellow green
    // channel (0xaa) is the only partial one
    localparam int    YEL_G_FULL = 8'hAA;
    localparam int    CHAN_MAX   = 255;
    localparam t_chan YEL_R_DIM  = 8'((CHAN_MAX * 25) / CHAN_MAX);
    localparam t_chan YEL_G_DIM  = 8'((YEL_G_FULL * 25) / CHAN_MAX);

    typedef struct packed {
        t_mode  mode;
        t_phase phase;
        t_ph10  ph10;
        t_ph100 ph100;
    } t_state;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
        t_mode mode_now;
    } t_pix;

endpackage

// ----- sv/slpg_if.sv -----
// slpg_if: valid/ready channel interfaces for requests and pixel results
// depends on slpg_pkg
`timescale 1ns / 1ps

interface slpg_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    slpg_pkg::t_mode    mode_in;

    modport source (output valid, output req_type, output mode_in, input ready);
    modport sink   (input valid, input req_type, input mode_in, output ready);
endinterface

interface slpg_pix_if;
    logic               valid;
    logic               ready;
    slpg_pkg::t_chan    red;
    slpg_pkg::t_chan    green;
    slpg_pkg::t_chan    blue;
    slpg_pkg::t_mode    mode_now;

    modport source (output valid, output red, output green, output blue,
                    output mode_now, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input mode_now, output ready);
endinterface

// ----- sv/slpg_state.sv -----
// slpg_state: display mode and tick phase registers with the next-phase counters
// depends on slpg_pkg
`timescale 1ns / 1ps

module slpg_state (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tick,
    input  logic              i_set,
    input  slpg_pkg::t_mode   i_set_mode,
    input  slpg_pkg::t_mode   i_tick_mode,
    output slpg_pkg::t_state  o_next
);
    import slpg_pkg::*;

    t_state r_st;
    t_state n_st;

    // phase after this tick, mode not yet updated
    always_comb begin
        o_next.mode  = r_st.mode;
        o_next.phase = (r_st.phase == PHASE_LAST) ? '0 : r_st.phase + 8'd1;
        o_next.ph10  = (r_st.ph10 == PH10_LAST)   ? '0 : r_st.ph10 + 4'd1;
        o_next.ph100 = (r_st.ph100 == PH100_LAST) ? '0 : r_st.ph100 + 7'd1;
    end

    always_comb begin
        n_st = r_st;
        if (i_set) begin
            n_st = '0;
            n_st.mode = i_set_mode;
        end else if (i_tick) begin
            n_st = o_next;
            n_st.mode = i_tick_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '{mode: MODE_BOOT, phase: '0, ph10: '0, ph100: '0};
        end else begin
            r_st <= n_st;
        end
    end

endmodule

// ----- sv/slpg_colour.sv -----
// slpg_colour: pattern and brightness logic for one tick, incl. failed fallback
// depends on slpg_pkg
`timescale 1ns / 1ps

module slpg_colour (
    input  slpg_pkg::t_state  i_next,
    output slpg_pkg::t_pix    o_pix
);
    import slpg_pkg::*;

    logic [8:0] w_q9;
    t_chan      w_boot_bri;
    logic       w_on10;
    logic       w_on8;

    assign w_q9   = {2'b00, i_next.ph100};
    assign w_on10 = (i_next.ph10 < 4'd5);
    assign w_on8  = ~i_next.phase[2];

    // triangle: rises by 5 per tick to the midpoint, then falls
    always_comb begin
        if (i_next.ph100 < 7'd50) begin
            w_boot_bri = 8'(w_q9 * 9'd5);
        end else begin
            w_boot_bri = 8'((9'd100 - w_q9) * 9'd5);
        end
    end

    always_comb begin
        o_pix          = '0;
        o_pix.mode_now = i_next.mode;
        unique case (i_next.mode)
            MODE_BOOT: begin
                o_pix.blue = w_boot_bri;
            end
            MODE_IDLE: begin
                o_pix.green = BRI_IDLE;
            end
            MODE_NO_SERVER: begin
                o_pix.red   = YEL_R_DIM;
                o_pix.green = YEL_G_DIM;
            end
            MODE_CALLING: begin
                o_pix.red   = w_on10 ? BRI_HIGH : '0;
                o_pix.green = w_on10 ? BRI_HIGH : '0;
                o_pix.blue  = w_on10 ? BRI_HIGH : '0;
            end
            MODE_RINGING: begin
                o_pix.green = w_on8 ? BRI_RING : '0;
                o_pix.blue  = w_on8 ? BRI_RING : '0;
            end
            MODE_IN_CALL: begin
                o_pix.green = BRI_HIGH;
            end
            MODE_FAILED: begin
                if (i_next.phase <= FAIL_LAST) begin
                    o_pix.red = w_on10 ? BRI_HIGH : '0;
                end else begin
                    o_pix.green    = BRI_IDLE;
                    o_pix.mode_now = MODE_IDLE;
                end
            end
            MODE_ERROR: begin
                o_pix.red = BRI_ERROR;
            end
            MODE_LOOPBACK: begin
                o_pix.blue = BRI_ERROR;
            end
            default: begin
                o_pix.red = '0;
            end
        endcase
    end

endmodule

// ----- sv/status_led_pattern_generator_top.sv -----
// status_led_pattern_generator_top: rgb status pixel pattern generator
// depends on slpg_pkg, slpg_if, slpg_state, slpg_colour
`timescale 1ns / 1ps
//
// channel   dir  modport          payload
// i_req     in   slpg_req_if.sink  req_type (1), mode_in (4)
// o_pix     out  slpg_pix_if.source red, green, blue (8 each), mode_now (4)
//
// one item per clock while results are taken; an accepted tick item passes
// through the input register, then the result register, before it is offered
// a set item gives no result and takes effect on the following item
// synchronous active-low reset: boot mode, phase zero, both registers empty
// a stalled result holds in the result register while the input register
// still takes the next item; input ready only drops while a tick item waits
// in the input register behind a result that is not being taken

module status_led_pattern_generator_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    slpg_req_if.sink        i_req,
    slpg_pix_if.source      o_pix
);
    import slpg_pkg::*;

    // input register
    logic   r_in_valid;
    logic   r_in_req;
    t_mode  r_in_mode;

    // result register
    logic   r_out_valid;
    t_pix   r_out;

    // pipeline control
    logic   w_out_free;
    logic   w_go;
    logic   w_tick;
    logic   w_set;
    logic   w_in_take;

    t_state w_next;
    t_pix   w_pix;

    // result register can load when empty or being drained this cycle
    assign w_out_free = !r_out_valid || o_pix.ready;
    // a set item never waits on the result side
    assign w_go       = r_in_valid && ((r_in_req == REQ_SET) || w_out_free);
    assign w_tick     = w_go && (r_in_req == REQ_TICK);
    assign w_set      = w_go && (r_in_req == REQ_SET);

    assign i_req.ready = !r_in_valid || w_go;
    assign w_in_take   = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_req  <= i_req.req_type;
            r_in_mode <= i_req.mode_in;
        end
    end

    // mode and phase state, updated as each item leaves the input register
    slpg_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (w_tick),
        .i_set       (w_set),
        .i_set_mode  (r_in_mode),
        .i_tick_mode (w_pix.mode_now),
        .o_next      (w_next)
    );

    // colour for the advanced phase
    slpg_colour u_colour (
        .i_next (w_next),
        .o_pix  (w_pix)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_tick) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_out <= w_pix;
        end
    end

    assign o_pix.valid    = r_out_valid;
    assign o_pix.red      = r_out.red;
    assign o_pix.green    = r_out.green;
    assign o_pix.blue     = r_out.blue;
    assign o_pix.mode_now = r_out.mode_now;

endmodule

// ----- sv/slpg_checker.sv -----
// slpg_checker: port-level assertions for the pattern generator top
// depends on slpg_pkg; bound to status_led_pattern_generator_top
`timescale 1ns / 1ps

module slpg_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  slpg_pkg::t_chan i_red,
    input  slpg_pkg::t_chan i_green,
    input  slpg_pkg::t_chan i_blue,
    input  slpg_pkg::t_mode i_mode_now
);
    import slpg_pkg::*;

    // no result straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // unknown modes show an unlit pixel
    a_unknown_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_mode_now > MODE_LOOPBACK)
        |-> (i_red == '0) && (i_green == '0) && (i_blue == '0))
        else $error("unknown mode not off");

    // idle, including fallback from failed, is dim green
    a_idle_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_mode_now == MODE_IDLE)
        |-> (i_red == '0) && (i_green == BRI_IDLE) && (i_blue == '0))
        else $error("idle colour wrong");

endmodule

bind status_led_pattern_generator_top slpg_checker u_slpg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_red       (o_pix.red),
    .i_green     (o_pix.green),
    .i_blue      (o_pix.blue),
    .i_mode_now  (o_pix.mode_now)
);
